// File: src/aica_pkg.sv
// ----------------------------------------------------------------------------
// aica_pkg
// Shared constants, codes and helpers for the activator-inhibitor cell update
// block.
// ----------------------------------------------------------------------------
package aica_pkg;

  localparam int GRID_SIZE = 32;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int GRID_W    = $clog2(GRID_SIZE);
  localparam int ADDR_W    = $clog2(CELLS);

  localparam int COORD_W   = 5;   // row / col field width
  localparam int RAD_W     = 7;   // radius and distance width
  localparam int WEIGHT_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int SUM_W     = ADDR_W + 1;
  localparam int SUM_OUT_W = 11;
  localparam int CLAMP_W   = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int SUM_LIMIT = 1023;
  localparam int PROD_W    = WEIGHT_W + SUM_W;
  localparam int ACC_W     = PROD_W + 2;

  localparam logic signed [WEIGHT_W-1:0] NEAR_WEIGHT_RST = 16'sd256;
  localparam logic signed [WEIGHT_W-1:0] FAR_WEIGHT_RST  = -16'sd26;
  localparam logic signed [WEIGHT_W-1:0] BIAS_RST        = 16'sd0;
  localparam logic [RAD_W-1:0]           NEAR_RADIUS_RST = 7'd1;
  localparam logic [RAD_W-1:0]           FAR_RADIUS_RST  = 7'd5;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_READ   = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_WEIGHT = 3'd0,
    CFG_FAR_WEIGHT  = 3'd1,
    CFG_BIAS        = 3'd2,
    CFG_NEAR_RADIUS = 3'd3,
    CFG_FAR_RADIUS  = 3'd4
  } cfg_index_t;

  // wrapped distance along one axis of the torus
  function automatic logic [RAD_W-1:0] axis_dist(input logic [RAD_W-1:0] a,
                                                 input logic [RAD_W-1:0] b);
    logic [RAD_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    if (d > RAD_W'(GRID_SIZE / 2)) d = RAD_W'(GRID_SIZE) - d;
    return d;
  endfunction

  function automatic logic signed [SUM_OUT_W-1:0] clamp_sum(
      input logic signed [SUM_W-1:0] s);
    logic signed [CLAMP_W-1:0] w;
    logic signed [CLAMP_W-1:0] lim;
    w   = CLAMP_W'(s);
    lim = CLAMP_W'(SUM_LIMIT);
    if (w > lim) w = lim;
    else if (w < -lim) w = -lim;
    return w[SUM_OUT_W-1:0];
  endfunction

endpackage

// File: src/aica_ram.sv
// ----------------------------------------------------------------------------
// aica_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aica_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/aica_cell_update_top.sv
// ----------------------------------------------------------------------------
// aica_cell_update_top
// Activator-inhibitor cellular automaton cell engine. Loads, reads or updates
// one cell of a toroidal grid held in a 1-bit RAM.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   req_valid / req_stall      req_type, row, col, load_value
//  response  rsp_valid / rsp_stall      cell_value, flipped, near_sum, far_sum
//  config    cfg_we                     cfg_index, cfg_data
//
//  Load and off-grid items go straight to emit; reads pass through S_READ.
//  Update: sweep, drain, multiply, decide, emit; the sweep reads one cell per
//  cycle through the single RAM read port.
//  One item is in flight at a time; a finished response may wait in the
//  output register while the next item is accepted and worked on.
//  Reset clears control, presets config; the grid is undefined until loaded.
// ----------------------------------------------------------------------------
module aica_cell_update_top (
  input  logic                                  clk,
  input  logic                                  rst,

  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            req_type,
  input  logic [aica_pkg::COORD_W-1:0]          row,
  input  logic [aica_pkg::COORD_W-1:0]          col,
  input  logic                                  load_value,

  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic                                  cell_value,
  output logic                                  flipped,
  output logic signed [aica_pkg::SUM_OUT_W-1:0] near_sum,
  output logic signed [aica_pkg::SUM_OUT_W-1:0] far_sum,

  input  logic                                  cfg_we,
  input  logic [aica_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aica_pkg::CFG_W-1:0]            cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_DRAIN,
    S_MUL,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic signed [aica_pkg::WEIGHT_W-1:0] near_weight;
  logic signed [aica_pkg::WEIGHT_W-1:0] far_weight;
  logic signed [aica_pkg::WEIGHT_W-1:0] bias;
  logic [aica_pkg::RAD_W-1:0]           near_radius;
  logic [aica_pkg::RAD_W-1:0]           far_radius;

  // addressed cell
  logic [aica_pkg::GRID_W-1:0] self_r;
  logic [aica_pkg::GRID_W-1:0] self_c;
  logic [aica_pkg::ADDR_W-1:0] self_addr;

  // sweep
  logic [aica_pkg::GRID_W-1:0] sweep_r;
  logic [aica_pkg::GRID_W-1:0] sweep_c;
  logic [aica_pkg::ADDR_W-1:0] sweep_addr;
  logic                        acc_en;
  logic                        hit_near;
  logic                        hit_far;
  logic                        hit_self;
  logic signed [aica_pkg::SUM_W-1:0]  near_acc;
  logic signed [aica_pkg::SUM_W-1:0]  far_acc;
  logic                               old_cell;
  logic signed [aica_pkg::PROD_W-1:0] near_prod;
  logic signed [aica_pkg::PROD_W-1:0] far_prod;

  // pending response
  logic                                  res_cell;
  logic                                  res_flip;
  logic signed [aica_pkg::SUM_OUT_W-1:0] res_near;
  logic signed [aica_pkg::SUM_OUT_W-1:0] res_far;

  // RAM port
  logic                        mem_we;
  logic [aica_pkg::ADDR_W-1:0] mem_waddr;
  logic                        mem_wdata;
  logic [aica_pkg::ADDR_W-1:0] mem_raddr;
  logic                        rd_data;

  // request decode
  logic [aica_pkg::RAD_W-1:0]  row_ext;
  logic [aica_pkg::RAD_W-1:0]  col_ext;
  logic [aica_pkg::GRID_W-1:0] req_r;
  logic [aica_pkg::GRID_W-1:0] req_c;
  logic [aica_pkg::ADDR_W-1:0] req_addr;
  logic                        on_grid;
  logic                        accept;

  logic [aica_pkg::RAD_W-1:0]        cell_gap;
  logic                              is_near;
  logic                              is_far;
  logic                              is_self;
  logic                              sweep_last;
  logic signed [aica_pkg::SUM_W-1:0] cell_step;
  logic signed [aica_pkg::ACC_W-1:0] acc_sum;
  logic                              new_cell;
  logic                              slot_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign row_ext  = aica_pkg::RAD_W'(row);
  assign col_ext  = aica_pkg::RAD_W'(col);
  assign req_r    = row_ext[aica_pkg::GRID_W-1:0];
  assign req_c    = col_ext[aica_pkg::GRID_W-1:0];
  assign on_grid  = (row_ext < aica_pkg::RAD_W'(aica_pkg::GRID_SIZE)) &&
                    (col_ext < aica_pkg::RAD_W'(aica_pkg::GRID_SIZE));
  assign req_addr = aica_pkg::ADDR_W'(req_r) * aica_pkg::ADDR_W'(aica_pkg::GRID_SIZE) +
                    aica_pkg::ADDR_W'(req_c);

  assign cell_gap = aica_pkg::axis_dist(aica_pkg::RAD_W'(self_r), aica_pkg::RAD_W'(sweep_r)) +
                    aica_pkg::axis_dist(aica_pkg::RAD_W'(self_c), aica_pkg::RAD_W'(sweep_c));
  assign is_near    = cell_gap < near_radius;
  assign is_far     = !is_near && (cell_gap < far_radius);
  assign is_self    = (sweep_addr == self_addr);
  assign sweep_last = (sweep_addr == aica_pkg::ADDR_W'(aica_pkg::CELLS - 1));

  assign cell_step = rd_data ? aica_pkg::SUM_W'(1) : {aica_pkg::SUM_W{1'b1}};

  assign acc_sum  = aica_pkg::ACC_W'(bias) + aica_pkg::ACC_W'(near_prod) +
                    aica_pkg::ACC_W'(far_prod);
  assign new_cell = !acc_sum[aica_pkg::ACC_W-1];

  assign slot_free = !rsp_valid || !rsp_stall;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_addr;
    mem_wdata = load_value;
    mem_raddr = sweep_addr;
    if (state == S_IDLE) begin
      mem_raddr = req_addr;
      if (accept && on_grid && (req_type == aica_pkg::REQ_LOAD)) mem_we = 1'b1;
    end else if (state == S_DECIDE) begin
      mem_we    = 1'b1;
      mem_waddr = self_addr;
      mem_wdata = new_cell;
    end
  end

  aica_ram #(
    .WIDTH (1),
    .DEPTH (aica_pkg::CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      acc_en      <= 1'b0;
      near_weight <= aica_pkg::NEAR_WEIGHT_RST;
      far_weight  <= aica_pkg::FAR_WEIGHT_RST;
      bias        <= aica_pkg::BIAS_RST;
      near_radius <= aica_pkg::NEAR_RADIUS_RST;
      far_radius  <= aica_pkg::FAR_RADIUS_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          aica_pkg::CFG_NEAR_WEIGHT: near_weight <= cfg_data;
          aica_pkg::CFG_FAR_WEIGHT:  far_weight  <= cfg_data;
          aica_pkg::CFG_BIAS:        bias        <= cfg_data;
          aica_pkg::CFG_NEAR_RADIUS: near_radius <= cfg_data[aica_pkg::RAD_W-1:0];
          aica_pkg::CFG_FAR_RADIUS:  far_radius  <= cfg_data[aica_pkg::RAD_W-1:0];
          default: ;
        endcase
      end

      // S_EMIT below owns rsp_valid in its own state
      if (rsp_valid && !rsp_stall && (state != S_EMIT)) rsp_valid <= 1'b0;

      // read data comes back the cycle after its address; class bits follow it
      acc_en   <= (state == S_SWEEP);
      hit_near <= is_near;
      hit_far  <= is_far;
      hit_self <= is_self;
      if (acc_en) begin
        if (hit_self) old_cell <= rd_data;
        else if (hit_near) near_acc <= near_acc + cell_step;
        else if (hit_far) far_acc <= far_acc + cell_step;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            self_r     <= req_r;
            self_c     <= req_c;
            self_addr  <= req_addr;
            sweep_r    <= '0;
            sweep_c    <= '0;
            sweep_addr <= '0;
            near_acc   <= '0;
            far_acc    <= '0;
            res_cell   <= 1'b0;
            res_flip   <= 1'b0;
            res_near   <= '0;
            res_far    <= '0;
            if (!on_grid) begin
              state <= S_EMIT;
            end else begin
              unique case (req_type)
                aica_pkg::REQ_LOAD: begin
                  res_cell <= load_value;
                  state    <= S_EMIT;
                end
                aica_pkg::REQ_UPDATE: state <= S_SWEEP;
                default:              state <= S_READ;  // reserved code reads
              endcase
            end
          end
        end
        S_READ: begin
          res_cell <= rd_data;
          state    <= S_EMIT;
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + aica_pkg::ADDR_W'(1);
          if (sweep_c == aica_pkg::GRID_W'(aica_pkg::GRID_SIZE - 1)) begin
            sweep_c <= '0;
            sweep_r <= sweep_r + aica_pkg::GRID_W'(1);
          end else begin
            sweep_c <= sweep_c + aica_pkg::GRID_W'(1);
          end
          if (sweep_last) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_MUL;
        S_MUL: begin
          near_prod <= aica_pkg::PROD_W'(near_weight) * aica_pkg::PROD_W'(near_acc);
          far_prod  <= aica_pkg::PROD_W'(far_weight) * aica_pkg::PROD_W'(far_acc);
          state     <= S_DECIDE;
        end
        S_DECIDE: begin
          res_cell <= new_cell;
          res_flip <= (new_cell != old_cell);
          res_near <= aica_pkg::clamp_sum(near_acc);
          res_far  <= aica_pkg::clamp_sum(far_acc);
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp_valid  <= 1'b1;
            cell_value <= res_cell;
            flipped    <= res_flip;
            near_sum   <= res_near;
            far_sum    <= res_far;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
